// ===== hw/rtl/hswrm_pkg.sv =====
// Package for the hashed sliding-window rate meter.
// Holds modes, default sizes and the queue entry type; no dependencies.
`default_nettype none
package hswrm_pkg;
   localparam int BucketCountDefault = 64;
   localparam int WindowDepthDefault = 16;
   localparam int RateWidth = 48;
   localparam int CountWidth = 5;
   localparam logic [63:0] UsecPerSecQ16 = 64'd65536000000;
   localparam logic [47:0] RateMax = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] hash_value;
      logic [63:0] time_stamp;
   } cmd_type;
endpackage
`default_nettype wire

// ===== hw/rtl/hswrm_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module hswrm_ram #(
   parameter int Width = 64,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write or registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/hswrm_front.sv =====
// Front end: takes request transfers into a two-entry command queue.
// Depends on hswrm_pkg.
`default_nettype none
module hswrm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire hswrm_pkg::cmd_type in_cmd,
   output logic                  cmd_valid,
   output hswrm_pkg::cmd_type    cmd,
   input  wire logic             cmd_take
);
   import hswrm_pkg::*;
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   logic       do_push, do_pop;

   assign full      = cnt_ff == 2'd2;
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cnt_ff != 2'd0;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rd_ff];

   // queue pointers and storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) q_ff[wr_ff] <= in_cmd;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("command queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !do_pop) else $error("pop from empty command queue");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("command queue count slip");
endmodule
`default_nettype wire

// ===== hw/rtl/hswrm_div.sv =====
// Restoring radix-2 divider, 64 by 64, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module hswrm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic [63:0] quo_ff, dsr_ff;
   logic [64:0] rem_ff, rem_sh;
   logic [6:0]  cnt_ff;
   logic        busy_ff;

   assign rem_sh   = {rem_ff[63:0], quo_ff[63]};
   assign done     = busy_ff && cnt_ff == 7'd0;
   assign quotient = quo_ff;

   // one shift-subtract step a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1; cnt_ff <= 7'd64;
         quo_ff <= dividend; dsr_ff <= divisor; rem_ff <= '0;
      end else if (busy_ff && cnt_ff != 7'd0) begin
         cnt_ff <= cnt_ff - 7'd1;
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_ff <= rem_sh - {1'b0, dsr_ff};
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/hswrm_back.sv =====
// Back end: per-bucket ring state RAM, window RAM, rate division, result register.
// Depends on hswrm_pkg, hswrm_ram and hswrm_div.
`default_nettype none
module hswrm_back #(
   parameter int BucketCount = hswrm_pkg::BucketCountDefault,
   parameter int WindowDepth = hswrm_pkg::WindowDepthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  wire hswrm_pkg::cmd_type    cmd,
   output logic                       cmd_take,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic                       rsp_accepted,
   output logic [hswrm_pkg::RateWidth-1:0]  rsp_rate_q16,
   output logic                       rsp_rate_saturated,
   output logic [hswrm_pkg::CountWidth-1:0] rsp_entry_count
);
   import hswrm_pkg::*;
   localparam int BW = (BucketCount > 1) ? $clog2(BucketCount) : 1;
   localparam int PW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
   localparam int FW = $clog2(WindowDepth + 1);
   localparam int AW = $clog2(BucketCount * WindowDepth);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_BUCKET, ST_META, ST_LOOK, ST_RDNEW, ST_WAITNEW, ST_ADD,
      ST_RDOLD, ST_WAITOLD, ST_MUL, ST_DIV, ST_DIVWAIT, ST_CLEAR, ST_OUT
   } state_type;

   state_type        state_ff;
   cmd_type          cmd_ff;
   logic [BW-1:0]    bkt_ff;
   logic [BW-1:0]    clr_ff;
   logic [FW-1:0]    cnt_ff;
   logic [PW-1:0]    old_ff;
   logic [63:0]      newest_ff, num_ff;
   logic             resp_ff, acc_ff, sat_ff;
   logic [RateWidth-1:0]  rate_ff;
   logic [CountWidth-1:0] ecnt_ff;
   logic             out_acc_ff, out_sat_ff;
   logic [RateWidth-1:0]  out_rate_ff;
   logic [CountWidth-1:0] out_cnt_ff;

   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [PW-1:0]    ram_off;
   logic [63:0]      ram_q, dur;
   logic             div_start, div_done;
   logic [63:0]      div_q;
   logic [PW:0]      pos_sum;
   logic [PW-1:0]    pos;
   logic             meta_we;
   logic [BW-1:0]    meta_addr;
   logic [FW+PW-1:0] meta_wdata, meta_q;
   logic [FW-1:0]    meta_fill;
   logic [PW-1:0]    meta_ptr;
   logic [PW-1:0]    old_next;
   logic             add_reject;
   logic             load_out;

   // ring position of oldest + offset, modulo the window depth
   always_comb begin
      pos_sum = {1'b0, old_ff} + {1'b0, ram_off};
      if (pos_sum >= (PW+1)'(WindowDepth)) pos_sum = pos_sum - (PW+1)'(WindowDepth);
      pos = pos_sum[PW-1:0];
   end

   assign add_reject = cnt_ff != '0 && newest_ff > cmd_ff.time_stamp;
   assign old_next   = (old_ff == PW'(WindowDepth - 1)) ? '0 : old_ff + PW'(1);
   assign meta_fill  = meta_q[FW+PW-1:PW];
   assign meta_ptr   = meta_q[PW-1:0];

   // RAM address and write control
   always_comb begin
      ram_off    = '0;
      ram_we     = 1'b0;
      meta_we    = 1'b0;
      meta_addr  = bkt_ff;
      meta_wdata = '0;
      unique case (state_ff)
         ST_RDNEW: ram_off = PW'(cnt_ff - FW'(1));
         ST_ADD: begin
            ram_we  = !add_reject;
            ram_off = (cnt_ff < FW'(WindowDepth)) ? PW'(cnt_ff) : '0;
            meta_we = !add_reject;
            meta_wdata = (cnt_ff < FW'(WindowDepth)) ? {cnt_ff + FW'(1), old_ff}
                                                     : {cnt_ff, old_next};
         end
         ST_INIT, ST_CLEAR: begin
            meta_we   = 1'b1;
            meta_addr = clr_ff;
         end
         default: ram_off = '0;
      endcase
      ram_addr = AW'(bkt_ff) * AW'(WindowDepth) + AW'(pos);
   end

   hswrm_ram #(.Width(64), .Depth(BucketCount * WindowDepth)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(cmd_ff.time_stamp), .rd_data(ram_q)
   );

   // fill count and oldest pointer per bucket
   hswrm_ram #(.Width(FW + PW), .Depth(BucketCount)) u_meta (
      .clock(clock), .wr_en(meta_we), .addr(meta_addr),
      .wr_data(meta_wdata), .rd_data(meta_q)
   );

   assign dur       = newest_ff - ram_q;
   assign div_start = state_ff == ST_DIV;
   hswrm_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(num_ff), .divisor(newest_ff), .done(div_done), .quotient(div_q)
   );

   assign cmd_take  = state_ff == ST_IDLE && cmd_valid;
   assign load_out  = state_ff == ST_OUT && (!resp_ff || rsp_pop);
   assign rsp_empty = !resp_ff;
   assign rsp_accepted = out_acc_ff;
   assign rsp_rate_q16 = out_rate_ff;
   assign rsp_rate_saturated = out_sat_ff;
   assign rsp_entry_count = out_cnt_ff;

   // result register, held while the transfer waits
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_acc_ff <= acc_ff; out_rate_ff <= rate_ff;
         out_sat_ff <= sat_ff; out_cnt_ff <= ecnt_ff;
      end
   end

   // sequencer and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         resp_ff  <= 1'b0;
         clr_ff   <= '0;
      end else begin
         if (load_out) resp_ff <= 1'b1;
         else if (rsp_pop) resp_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               if (clr_ff == BW'(BucketCount - 1)) begin
                  clr_ff <= '0; state_ff <= ST_IDLE;
               end else begin
                  clr_ff <= clr_ff + BW'(1);
               end
            end
            ST_IDLE: if (cmd_valid) begin
               cmd_ff <= cmd; state_ff <= ST_BUCKET;
            end
            ST_BUCKET: begin
               bkt_ff   <= BW'(cmd_ff.hash_value % BucketCount);
               state_ff <= ST_META;
            end
            ST_META: state_ff <= ST_LOOK;
            ST_LOOK: begin
               cnt_ff <= meta_fill;
               old_ff <= meta_ptr;
               acc_ff <= 1'b1; rate_ff <= '0; sat_ff <= 1'b0;
               ecnt_ff <= CountWidth'(meta_fill);
               case (mode_type'(cmd_ff.mode))
                  MODE_ADD: state_ff <= (meta_fill != '0) ? ST_RDNEW : ST_ADD;
                  MODE_QUERY: state_ff <= (meta_fill > FW'(1)) ? ST_RDNEW : ST_OUT;
                  MODE_CLEAR: state_ff <= ST_CLEAR;
                  default: state_ff <= ST_OUT;
               endcase
            end
            ST_RDNEW: state_ff <= ST_WAITNEW;
            ST_WAITNEW: begin
               newest_ff <= ram_q;
               state_ff <= (cmd_ff.mode == MODE_ADD) ? ST_ADD : ST_RDOLD;
            end
            ST_ADD: begin
               if (add_reject) begin
                  acc_ff <= 1'b0;
               end else if (cnt_ff < FW'(WindowDepth)) begin
                  ecnt_ff <= CountWidth'(cnt_ff + FW'(1));
               end
               state_ff <= ST_OUT;
            end
            ST_RDOLD: state_ff <= ST_WAITOLD;
            ST_WAITOLD: begin
               newest_ff <= dur;
               num_ff <= 64'(cnt_ff) * UsecPerSecQ16;
               if (dur == '0) begin
                  rate_ff <= RateMax; sat_ff <= 1'b1; state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_DIV;
            ST_DIV: state_ff <= ST_DIVWAIT;
            ST_DIVWAIT: if (div_done) begin
               if (div_q[63:RateWidth] != '0) begin
                  rate_ff <= RateMax; sat_ff <= 1'b1;
               end else begin
                  rate_ff <= div_q[RateWidth-1:0];
               end
               state_ff <= ST_OUT;
            end
            // clearing pass, one bucket a cycle
            ST_CLEAR: begin
               ecnt_ff <= '0;
               if (clr_ff == BW'(BucketCount - 1)) begin
                  clr_ff <= '0; state_ff <= ST_OUT;
               end else begin
                  clr_ff <= clr_ff + BW'(1);
               end
            end
            ST_OUT: if (load_out) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_ADD) else $error("window write outside add");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVWAIT && div_done) |=> state_ff == ST_OUT)
      else $error("divider result not taken");
   assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> state_ff == ST_BUCKET) else $error("command lost");
endmodule
`default_nettype wire

// ===== hw/rtl/hashed_sliding_window_rate_meter.sv =====
// Top level of the hashed sliding-window rate meter.
// Depends on hswrm_pkg, hswrm_front and hswrm_back.
//
//  channel  | handshake           | fields
//  request  | req_push / req_full | req_mode, req_hash_value, req_time_stamp
//  response | rsp_empty / rsp_pop | rsp_accepted, rsp_rate_q16, rsp_rate_saturated,
//           |                     | rsp_entry_count
//
// From request transfer to result: add reads the newest entry unless the bucket is
// empty; a query with two or more entries reads newest and oldest, then the 64-step
// shift-subtract divider runs on a nonzero duration; clear does one bucket a cycle.
// After reset a clearing pass over every bucket runs before the first command.
// A waiting result stalls the back end; the front queue still takes two transfers.
`default_nettype none
module hashed_sliding_window_rate_meter #(
   parameter int BucketCount = hswrm_pkg::BucketCountDefault,
   parameter int WindowDepth = hswrm_pkg::WindowDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_hash_value,
   input  wire logic [63:0] req_time_stamp,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_accepted,
   output logic [47:0]      rsp_rate_q16,
   output logic             rsp_rate_saturated,
   output logic [4:0]       rsp_entry_count
);
   import hswrm_pkg::*;
   cmd_type in_cmd, cmd;
   logic    cmd_valid, cmd_take;

   assign in_cmd = '{mode: req_mode, hash_value: req_hash_value, time_stamp: req_time_stamp};

   hswrm_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .in_cmd(in_cmd), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
   );

   hswrm_back #(.BucketCount(BucketCount), .WindowDepth(WindowDepth)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_accepted(rsp_accepted), .rsp_rate_q16(rsp_rate_q16),
      .rsp_rate_saturated(rsp_rate_saturated), .rsp_entry_count(rsp_entry_count)
   );
endmodule
`default_nettype wire

// ===== bench/hashed_sliding_window_rate_meter_tb.sv =====
// Self-checking bench for the hashed sliding-window rate meter.
// Depends on hswrm_pkg and hashed_sliding_window_rate_meter; predicts every result in-line.
`default_nettype none
module hashed_sliding_window_rate_meter_tb;
   import hswrm_pkg::*;

   localparam int Buckets = BucketCountDefault;
   localparam int Depth = WindowDepthDefault;
   localparam longint CycleLimit = 2000000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_mode;
   logic [31:0] req_hash_value;
   logic [63:0] req_time_stamp;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_accepted;
   logic [47:0] rsp_rate_q16;
   logic        rsp_rate_saturated;
   logic [4:0]  rsp_entry_count;

   hashed_sliding_window_rate_meter dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_mode(req_mode),
      .req_hash_value(req_hash_value), .req_time_stamp(req_time_stamp),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_accepted(rsp_accepted),
      .rsp_rate_q16(rsp_rate_q16), .rsp_rate_saturated(rsp_rate_saturated),
      .rsp_entry_count(rsp_entry_count)
   );

   typedef struct {
      logic        accepted;
      logic [47:0] rate;
      logic        saturated;
      logic [4:0]  count;
   } meter_result_type;

   // predictor state: per-bucket ring of timestamps
   logic [63:0] ring_ts [Buckets][Depth];
   int unsigned ring_fill [Buckets];
   int unsigned ring_head [Buckets];
   meter_result_type pending_results[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   bit          stall_enable = 1;
   logic [63:0] flow_time [Buckets];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("hashed_sliding_window_rate_meter_tb: FAIL");
         $finish;
      end
   end

   function automatic meter_result_type predict_meter(logic [1:0] mode, logic [31:0] hash,
                                                     logic [63:0] ts);
      meter_result_type r;
      int unsigned b;
      int unsigned n;
      logic [63:0] newest;
      logic [63:0] dur;
      logic [63:0] quot;
      b = hash % Buckets;
      n = ring_fill[b];
      r.accepted = 1'b1;
      r.rate = '0;
      r.saturated = 1'b0;
      case (mode)
         MODE_ADD: begin
            if (n != 0 && ring_ts[b][(ring_head[b] + n - 1) % Depth] > ts) begin
               r.accepted = 1'b0;
            end else if (n < Depth) begin
               ring_ts[b][(ring_head[b] + n) % Depth] = ts;
               n++;
               ring_fill[b] = n;
            end else begin
               ring_ts[b][ring_head[b]] = ts;
               ring_head[b] = (ring_head[b] + 1) % Depth;
            end
         end
         MODE_QUERY: begin
            if (n > 1) begin
               newest = ring_ts[b][(ring_head[b] + n - 1) % Depth];
               dur = newest - ring_ts[b][ring_head[b]];
               if (dur == 0) begin
                  r.rate = RateMax;
                  r.saturated = 1'b1;
               end else begin
                  quot = (64'(n) * UsecPerSecQ16) / dur;
                  if (quot > 64'(RateMax)) begin
                     r.rate = RateMax;
                     r.saturated = 1'b1;
                  end else begin
                     r.rate = quot[47:0];
                  end
               end
            end
         end
         MODE_CLEAR: begin
            foreach (ring_fill[i]) begin
               ring_fill[i] = 0;
               ring_head[i] = 0;
            end
            n = 0;
         end
         default: ;
      endcase
      r.count = 5'(n);
      return r;
   endfunction

   function automatic int unsigned short_gap();
      if (!stall_enable) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   // one request transfer, predicted at acceptance; push stays high for a following item
   task automatic send_item(logic [1:0] mode, logic [31:0] hash, logic [63:0] ts);
      int unsigned gap;
      gap = short_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_hash_value <= hash;
      req_time_stamp <= ts;
      do @(posedge clock); while (req_full);
      pending_results.push_back(predict_meter(mode, hash, ts));
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // response side: random pop stalls, compare on each transfer
   initial begin
      meter_result_type want;
      int unsigned wait_cycles;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  $error("accepted: expected %0d got %0d", want.accepted, rsp_accepted);
                  error_count++;
               end
               if (rsp_rate_q16 !== want.rate) begin
                  $error("rate_q16: expected %0h got %0h", want.rate, rsp_rate_q16);
                  error_count++;
               end
               if (rsp_rate_saturated !== want.saturated) begin
                  $error("rate_saturated: expected %0d got %0d", want.saturated,
                         rsp_rate_saturated);
                  error_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d got %0d", want.count, rsp_entry_count);
                  error_count++;
               end
            end
         end
         wait_cycles = short_gap();
         if (wait_cycles != 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   // extremes, every mode, equal/older timestamps, saturation and few entries
   task automatic test_directed();
      send_item(MODE_QUERY, 32'd5, 64'd0);
      send_item(MODE_ADD, 32'd5, 64'd100);
      send_item(MODE_QUERY, 32'd5, 64'd0);
      send_item(MODE_ADD, 32'd5, 64'd100);
      send_item(MODE_QUERY, 32'd5, 64'd0);
      send_item(MODE_ADD, 32'd5, 64'd99);
      send_item(MODE_ADD, 32'd5, 64'd101);
      send_item(MODE_QUERY, 32'hFFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(MODE_ADD, 32'hFFFF_FFFF, 64'd0);
      send_item(MODE_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(MODE_QUERY, 32'hFFFF_FFFF, 64'd0);
      send_item(MODE_NONE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(MODE_NONE, 32'd0, 64'd0);
      send_item(MODE_CLEAR, 32'd5, 64'd0);
      send_item(MODE_QUERY, 32'd5, 64'd0);
      // fill past the window depth so the ring wraps
      for (int i = 0; i < Depth + 3; i++) send_item(MODE_ADD, 32'd7, 64'(1000 * i));
      send_item(MODE_QUERY, 32'd7, 64'd0);
   endtask

   // mostly monotonic per-flow sequences, with some out-of-order noise
   task automatic test_random(int unsigned items);
      int unsigned b;
      int unsigned pick;
      logic [1:0] mode;
      logic [31:0] hash;
      logic [63:0] ts;
      foreach (flow_time[i]) flow_time[i] = 0;
      for (int k = 0; k < items; k++) begin
         b = $urandom_range(0, 7);
         hash = {26'($urandom_range(0, 32'h03FF_FFFF)), 6'(b)};
         hash = $urandom_range(0, 1) ? hash : ($urandom() & 32'hFFFF_FFC0) | b;
         pick = $urandom_range(0, 99);
         mode = (pick < 60) ? MODE_ADD : (pick < 95) ? MODE_QUERY :
                (pick < 97) ? MODE_CLEAR : MODE_NONE;
         case ($urandom_range(0, 9))
            0: ts = {$urandom(), $urandom()};
            1: ts = flow_time[b];
            2: ts = flow_time[b] - $urandom_range(0, 50);
            3: ts = flow_time[b] + {$urandom(), $urandom()} % 64'h0000_1000_0000_0000;
            default: ts = flow_time[b] + $urandom_range(0, 3000);
         endcase
         if (mode == MODE_ADD && ts >= flow_time[b]) flow_time[b] = ts;
         if (mode == MODE_CLEAR) foreach (flow_time[i]) flow_time[i] = 0;
         send_item(mode, hash, ts);
      end
   endtask

   task automatic test_pause_until_empty();
      drain_results();
      for (int i = 0; i < 4; i++) send_item(MODE_ADD, 32'd9, 64'(i));
      send_item(MODE_QUERY, 32'd9, 64'd0);
   endtask

   task automatic test_back_to_back();
      stall_enable = 0;
      for (int i = 0; i < 60; i++)
         send_item(i % 2 ? MODE_QUERY : MODE_ADD, 32'(i % 5), 64'(i * 17));
      stall_enable = 1;
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_mode = MODE_ADD;
      req_hash_value = '0;
      req_time_stamp = '0;
      foreach (ring_fill[i]) begin
         ring_fill[i] = 0;
         ring_head[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(550);
      test_pause_until_empty();
      test_back_to_back();
      test_random(550);
      drain_results();
      if (error_count == 0) begin
         $display("hashed_sliding_window_rate_meter_tb: PASS");
      end else begin
         $display("hashed_sliding_window_rate_meter_tb: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
